@@ rtl/gsed_pkg.sv @@
// Shared types and constants of the grayscale Sobel edge threshold unit.
`default_nettype none

package gsed_pkg;

	// Widths of the configuration registers and of the result fields.
	localparam int unsigned CFG_WIDTH_W  = 11;
	localparam int unsigned CFG_HEIGHT_W = 12;
	localparam int unsigned CFG_THRESH_W = 21;
	localparam int unsigned CFG_EDGE_W   = 8;
	localparam int unsigned CFG_ADDR_W   = 2;
	localparam int unsigned CFG_DATA_W   = 21;

	localparam int unsigned VALUE_W  = 8;
	localparam int unsigned ROW_W    = 12;
	localparam int unsigned COL_W    = 10;
	localparam int unsigned RES_BITS = VALUE_W + ROW_W + COL_W;
	localparam int unsigned M_TDATA_W = ((RES_BITS + 7) / 8) * 8;

	// Reset values of the configuration registers.
	localparam logic [CFG_WIDTH_W-1:0]  RST_WIDTH  = 11'd512;
	localparam logic [CFG_HEIGHT_W-1:0] RST_HEIGHT = 12'd512;
	localparam logic [CFG_THRESH_W-1:0] RST_THRESH = 21'd12000;
	localparam logic [CFG_EDGE_W-1:0]   RST_EDGE   = 8'd255;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_IMAGE_WIDTH  = 2'd0,
		CFG_IMAGE_HEIGHT = 2'd1,
		CFG_MAG_THRESH   = 2'd2,
		CFG_EDGE_VALUE   = 2'd3
	} cfg_reg_t;

	// Kind of an input transaction, carried in tuser.
	typedef enum logic [0:0] {
		MODE_PIXEL = 1'b0,
		MODE_FLUSH = 1'b1
	} mode_t;

	// Result bookkeeping that travels with an item down the pipeline.
	typedef struct packed {
		logic             a_vld;
		logic             b_vld;
		logic             a_sobel;
		logic             a_last;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] a_col;
		logic [COL_W-1:0] b_col;
	} meta_t;

	// One result item as it leaves the block.
	typedef struct packed {
		logic               last;
		logic [COL_W-1:0]   col;
		logic [ROW_W-1:0]   row;
		logic [VALUE_W-1:0] value;
	} res_t;

endpackage

`default_nettype wire

@@ rtl/gsed_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module gsed_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/gsed_front.sv @@
// Input stage: raster position tracking, gray conversion and line buffer read issue.
`default_nettype none

module gsed_front #(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 8,
	localparam int COL_BITS = $clog2(MAX_WIDTH)
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 en_s1,
	input  wire logic                                 in_valid,
	input  wire logic                                 in_flush,
	input  wire logic [PIXEL_BITS-1:0]                red,
	input  wire logic [PIXEL_BITS-1:0]                green,
	input  wire logic [PIXEL_BITS-1:0]                blue,
	input  wire logic [gsed_pkg::CFG_WIDTH_W-1:0]     cfg_width,
	input  wire logic [gsed_pkg::CFG_HEIGHT_W-1:0]    cfg_height,
	output logic                                      rd_en,
	output logic      [COL_BITS-1:0]                  rd_addr,
	output logic                                      v_s1,
	output logic                                      pix_s1,
	output gsed_pkg::meta_t                           meta_s1,
	output logic      [COL_BITS-1:0]                  col_s1,
	output logic      [PIXEL_BITS-1:0]                gray_s1
);

	localparam int SUM_W      = PIXEL_BITS + 2;
	localparam int GRAY_SHIFT = PIXEL_BITS + 4;
	localparam int RECIP      = ((1 << GRAY_SHIFT) + 2) / 3;
	localparam int PROD_W     = SUM_W + GRAY_SHIFT;

	logic [gsed_pkg::ROW_W-1:0] in_row_q;
	logic [COL_BITS-1:0]        in_col_q;
	logic [COL_BITS-1:0]        flush_col_q;

	logic [COL_BITS-1:0]        w_last;
	logic [gsed_pkg::ROW_W-1:0] h_last;
	logic [gsed_pkg::ROW_W-1:0] r;
	logic [COL_BITS-1:0]        c;
	logic [COL_BITS-1:0]        fc;
	logic                       row_end;
	logic                       flush_end;
	logic                       accept;
	logic [SUM_W-1:0]           sum;
	logic [PROD_W-1:0]          prod;
	logic [PIXEL_BITS-1:0]      gray;
	gsed_pkg::meta_t            meta;

	// Effective frame size, and positions limited to it.
	always_comb begin
		if (cfg_width < 11'd3) begin
			w_last = COL_BITS'(2);
		end else if (32'(cfg_width) > MAX_WIDTH) begin
			w_last = COL_BITS'(MAX_WIDTH - 1);
		end else begin
			w_last = COL_BITS'(cfg_width - 11'd1);
		end
		h_last = (cfg_height < 12'd3) ? 12'd2 : cfg_height - 12'd1;
		r      = (in_row_q > h_last) ? h_last : in_row_q;
		c      = (in_col_q > w_last) ? w_last : in_col_q;
		fc     = (flush_col_q > w_last) ? w_last : flush_col_q;
	end

	assign row_end   = (c == w_last);
	assign flush_end = (fc == w_last);
	assign accept    = in_valid && en_s1;

	// Gray level as the channel sum times a reciprocal of three.
	assign sum  = SUM_W'(red) + SUM_W'(green) + SUM_W'(blue);
	assign prod = PROD_W'(sum) * PROD_W'(RECIP);
	assign gray = prod[GRAY_SHIFT +: PIXEL_BITS];

	// Which results this transaction causes, and where they sit in the frame.
	always_comb begin
		meta.a_vld   = in_flush || (r != '0 && c != '0);
		meta.b_vld   = !in_flush && r != '0 && row_end;
		meta.a_sobel = !in_flush && r > 12'd1 && c > COL_BITS'(1);
		meta.a_last  = in_flush && flush_end;
		meta.row     = in_flush ? h_last : r - 12'd1;
		meta.a_col   = in_flush ? gsed_pkg::COL_W'(fc) : gsed_pkg::COL_W'(c - COL_BITS'(1));
		meta.b_col   = gsed_pkg::COL_W'(c);
	end

	// The line buffers are read at the current column when a pixel is taken.
	assign rd_en   = accept && !in_flush;
	assign rd_addr = c;

	// Position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q    <= '0;
			in_col_q    <= '0;
			flush_col_q <= '0;
		end else if (accept) begin
			if (in_flush) begin
				flush_col_q <= flush_end ? '0 : fc + COL_BITS'(1);
			end else if (row_end) begin
				in_col_q <= '0;
				in_row_q <= (r == h_last) ? '0 : r + 12'd1;
			end else begin
				in_col_q <= c + COL_BITS'(1);
				in_row_q <= r;
			end
		end
	end

	// Input register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= !in_flush;
			meta_s1 <= meta;
			col_s1  <= c;
			gray_s1 <= gray;
		end
	end

endmodule

`default_nettype wire

@@ rtl/gsed_grad.sv @@
// Window, Sobel gradients and their squares.
`default_nettype none

module gsed_grad #(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 8,
	localparam int COL_BITS = $clog2(MAX_WIDTH),
	localparam int SQ_W     = 2 * (PIXEL_BITS + 2)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en_s2,
	input  wire logic                  en_s3,
	input  wire logic                  v_s1,
	input  wire logic                  pix_s1,
	input  wire gsed_pkg::meta_t       meta_s1,
	input  wire logic [COL_BITS-1:0]   col_s1,
	input  wire logic [PIXEL_BITS-1:0] gray_s1,
	input  wire logic [PIXEL_BITS-1:0] up_rd,
	input  wire logic [PIXEL_BITS-1:0] mid_rd,
	output logic                       ram_we,
	output logic      [COL_BITS-1:0]   ram_waddr,
	output logic      [PIXEL_BITS-1:0] up_wdata,
	output logic      [PIXEL_BITS-1:0] mid_wdata,
	output logic                       v_s2,
	output logic                       v_s3,
	output gsed_pkg::meta_t            meta_s3,
	output logic      [SQ_W-1:0]       sqx_s3,
	output logic      [SQ_W-1:0]       sqy_s3
);

	localparam int GRAD_W = PIXEL_BITS + 3;
	localparam int MAG_W  = PIXEL_BITS + 2;

	// Middle and right columns of the window; the left one is not needed after a shift.
	logic [PIXEL_BITS-1:0] win_mid_q   [3];
	logic [PIXEL_BITS-1:0] win_right_q [3];

	logic signed [GRAD_W-1:0] gx;
	logic signed [GRAD_W-1:0] gy;
	logic signed [GRAD_W-1:0] gx_s2;
	logic signed [GRAD_W-1:0] gy_s2;
	gsed_pkg::meta_t          meta_s2;
	logic [MAG_W-1:0]         ax;
	logic [MAG_W-1:0]         ay;
	logic                     shift;

	function automatic logic signed [GRAD_W-1:0] ext(input logic [PIXEL_BITS-1:0] v);
		return $signed({3'b000, v});
	endfunction

	function automatic logic [MAG_W-1:0] magnitude(input logic signed [GRAD_W-1:0] g);
		logic [GRAD_W-1:0] neg;
		neg = -g;
		return g[GRAD_W-1] ? neg[MAG_W-1:0] : g[MAG_W-1:0];
	endfunction

	// A pixel leaving the input register shifts the window and updates the buffers.
	assign shift     = en_s2 && v_s1 && pix_s1;
	assign ram_we    = shift;
	assign ram_waddr = col_s1;
	assign up_wdata  = mid_rd;
	assign mid_wdata = gray_s1;

	// Gradients of the shifted window: left column is the old middle,
	// middle is the old right, right is the column just read.
	always_comb begin
		gx = ext(win_mid_q[0]) + (ext(win_mid_q[1]) <<< 1) + ext(win_mid_q[2])
			- ext(up_rd) - (ext(mid_rd) <<< 1) - ext(gray_s1);
		gy = ext(win_mid_q[0]) + (ext(win_right_q[0]) <<< 1) + ext(up_rd)
			- ext(win_mid_q[2]) - (ext(win_right_q[2]) <<< 1) - ext(gray_s1);
	end

	// Window registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				win_mid_q[i]   <= '0;
				win_right_q[i] <= '0;
			end
		end else if (shift) begin
			win_mid_q   <= win_right_q;
			win_right_q <= '{up_rd, mid_rd, gray_s1};
		end
	end

	// Valid flags of the gradient and square stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	assign ax = magnitude(gx_s2);
	assign ay = magnitude(gy_s2);

	// Gradient and square stage payload.
	always_ff @(posedge clk) begin
		if (en_s2) begin
			gx_s2   <= gx;
			gy_s2   <= gy;
			meta_s2 <= meta_s1;
		end
		if (en_s3) begin
			sqx_s3  <= SQ_W'(ax) * SQ_W'(ax);
			sqy_s3  <= SQ_W'(ay) * SQ_W'(ay);
			meta_s3 <= meta_s2;
		end
	end

endmodule

`default_nettype wire

@@ rtl/gsed_out.sv @@
// Threshold compare and output register with room for a second result.
`default_nettype none

module gsed_out #(
	parameter int PIXEL_BITS = 8,
	localparam int SQ_W = 2 * (PIXEL_BITS + 2)
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                m_tready,
	input  wire logic                                v_s3,
	input  wire gsed_pkg::meta_t                     meta_s3,
	input  wire logic [SQ_W-1:0]                     sqx_s3,
	input  wire logic [SQ_W-1:0]                     sqy_s3,
	input  wire logic [gsed_pkg::CFG_THRESH_W-1:0]   threshold,
	input  wire logic [gsed_pkg::CFG_EDGE_W-1:0]     edge_value,
	output logic                                     adv_out,
	output logic                                     m_tvalid,
	output gsed_pkg::res_t                           cur_q
);

	localparam int SUM_W = SQ_W + 1;
	localparam int CMP_W = (SUM_W > gsed_pkg::CFG_THRESH_W) ? SUM_W : gsed_pkg::CFG_THRESH_W;

	logic [1:0]     cnt_q;
	gsed_pkg::res_t pend_q;
	gsed_pkg::res_t a_res;
	gsed_pkg::res_t b_res;
	logic [SUM_W-1:0] mag;
	logic           hit;
	logic           shift_pend;

	// Squared magnitude against the threshold.
	assign mag = SUM_W'(sqx_s3) + SUM_W'(sqy_s3);
	assign hit = CMP_W'(mag) > CMP_W'(threshold);

	// The two results an item may cause; the second is always a border zero.
	always_comb begin
		a_res.value = (meta_s3.a_sobel && hit) ? edge_value : '0;
		a_res.row   = meta_s3.row;
		a_res.col   = meta_s3.a_col;
		a_res.last  = meta_s3.a_last;
		b_res.value = '0;
		b_res.row   = meta_s3.row;
		b_res.col   = meta_s3.b_col;
		b_res.last  = 1'b0;
	end

	// A new item may enter once at most the current result is left and it goes now.
	assign adv_out    = (cnt_q == 2'd0) || (cnt_q == 2'd1 && m_tready);
	assign shift_pend = (cnt_q == 2'd2) && m_tready;
	assign m_tvalid   = (cnt_q != 2'd0);

	// Count of results held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (adv_out) begin
			cnt_q <= v_s3 ? {1'b0, meta_s3.a_vld} + {1'b0, meta_s3.b_vld} : 2'd0;
		end else if (shift_pend) begin
			cnt_q <= 2'd1;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (adv_out) begin
			cur_q  <= a_res;
			pend_q <= b_res;
		end else if (shift_pend) begin
			cur_q <= pend_q;
		end
	end

	// The held second result is the next one shown.
	a_pend_next: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && m_tready) |=> (cnt_q == 2'd1 && cur_q == $past(pend_q)))
		else $error("second result not delivered next");

	// A frame's final result never shares the output register with another.
	a_last_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> (!cur_q.last && !pend_q.last))
		else $error("frame end paired with another result");

endmodule

`default_nettype wire

@@ rtl/grayscale_sobel_edge_threshold_unit.sv @@
// Top level of the grayscale Sobel edge threshold unit.
//
// Channel   Direction  Signals                              Contents
// s_axis    in         s_tvalid s_tready s_tdata s_tuser    RGB pixel or flush tick
// m_axis    out        m_tvalid m_tready m_tdata m_tlast    edge pixel with position
// cfg       in         cfg_we cfg_addr cfg_wdata            width, height, threshold, edge
//
// One transaction is taken per cycle while s_tready is high; its first result is shown on m_axis
// after the input, gradient and square registers and then the output register.
// The last pixel of a row other than the first causes two results, which the output side
// shows one after the other; every other transaction causes at most one.
// The line buffers are two 1-write, 1-read RAMs read at the column of the pixel
// being taken; they need no clearing pass after reset.
// A stalled output fills the pipeline bubbles first, then drops s_tready.
`default_nettype none

module grayscale_sobel_edge_threshold_unit #(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 8,
	localparam int S_TDATA_W = ((3 * PIXEL_BITS + 7) / 8) * 8,
	localparam int COL_BITS  = $clog2(MAX_WIDTH)
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// red, green, blue
	input  wire logic [S_TDATA_W-1:0]              s_tdata,
	// mode
	input  wire logic [0:0]                        s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// edge_pixel, pixel_row, pixel_col
	output logic [gsed_pkg::M_TDATA_W-1:0]         m_tdata,
	output logic                                   m_tlast,
	input  wire logic                              cfg_we,
	input  wire logic [gsed_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  wire logic [gsed_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	localparam int SQ_W = 2 * (PIXEL_BITS + 2);

	logic [gsed_pkg::CFG_WIDTH_W-1:0]  cfg_width_q;
	logic [gsed_pkg::CFG_HEIGHT_W-1:0] cfg_height_q;
	logic [gsed_pkg::CFG_THRESH_W-1:0] cfg_thresh_q;
	logic [gsed_pkg::CFG_EDGE_W-1:0]   cfg_edge_q;

	logic                  en_s1;
	logic                  en_s2;
	logic                  en_s3;
	logic                  adv_out;
	logic                  v_s1;
	logic                  v_s2;
	logic                  v_s3;
	logic                  pix_s1;
	gsed_pkg::meta_t       meta_s1;
	gsed_pkg::meta_t       meta_s3;
	logic [COL_BITS-1:0]   col_s1;
	logic [PIXEL_BITS-1:0] gray_s1;
	logic [SQ_W-1:0]       sqx_s3;
	logic [SQ_W-1:0]       sqy_s3;
	gsed_pkg::res_t        res;

	logic                  ram_re;
	logic [COL_BITS-1:0]   ram_raddr;
	logic                  ram_we;
	logic [COL_BITS-1:0]   ram_waddr;
	logic [PIXEL_BITS-1:0] up_wdata;
	logic [PIXEL_BITS-1:0] mid_wdata;
	logic [PIXEL_BITS-1:0] up_rd;
	logic [PIXEL_BITS-1:0] mid_rd;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width_q  <= gsed_pkg::RST_WIDTH;
			cfg_height_q <= gsed_pkg::RST_HEIGHT;
			cfg_thresh_q <= gsed_pkg::RST_THRESH;
			cfg_edge_q   <= gsed_pkg::RST_EDGE;
		end else if (cfg_we) begin
			unique case (gsed_pkg::cfg_reg_t'(cfg_addr))
				gsed_pkg::CFG_IMAGE_WIDTH: begin
					cfg_width_q <= cfg_wdata[gsed_pkg::CFG_WIDTH_W-1:0];
				end
				gsed_pkg::CFG_IMAGE_HEIGHT: begin
					cfg_height_q <= cfg_wdata[gsed_pkg::CFG_HEIGHT_W-1:0];
				end
				gsed_pkg::CFG_MAG_THRESH: begin
					cfg_thresh_q <= cfg_wdata[gsed_pkg::CFG_THRESH_W-1:0];
				end
				gsed_pkg::CFG_EDGE_VALUE: begin
					cfg_edge_q <= cfg_wdata[gsed_pkg::CFG_EDGE_W-1:0];
				end
			endcase
		end
	end

	// Each stage moves when the one after it moves or it holds nothing.
	assign en_s3    = adv_out || !v_s3;
	assign en_s2    = en_s3 || !v_s2;
	assign en_s1    = en_s2 || !v_s1;
	assign s_tready = en_s1;

	gsed_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en_s1      (en_s1),
		.in_valid   (s_tvalid),
		.in_flush   (s_tuser == gsed_pkg::MODE_FLUSH),
		.red        (s_tdata[PIXEL_BITS-1:0]),
		.green      (s_tdata[2*PIXEL_BITS-1:PIXEL_BITS]),
		.blue       (s_tdata[3*PIXEL_BITS-1:2*PIXEL_BITS]),
		.cfg_width  (cfg_width_q),
		.cfg_height (cfg_height_q),
		.rd_en      (ram_re),
		.rd_addr    (ram_raddr),
		.v_s1       (v_s1),
		.pix_s1     (pix_s1),
		.meta_s1    (meta_s1),
		.col_s1     (col_s1),
		.gray_s1    (gray_s1)
	);

	// Line buffers: the row two above and the row above the incoming one.
	gsed_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (MAX_WIDTH)
	) u_lb_upper (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (up_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (up_rd)
	);

	gsed_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (MAX_WIDTH)
	) u_lb_middle (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (mid_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (mid_rd)
	);

	gsed_grad #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS)
	) u_grad (
		.clk       (clk),
		.arst_n    (arst_n),
		.en_s2     (en_s2),
		.en_s3     (en_s3),
		.v_s1      (v_s1),
		.pix_s1    (pix_s1),
		.meta_s1   (meta_s1),
		.col_s1    (col_s1),
		.gray_s1   (gray_s1),
		.up_rd     (up_rd),
		.mid_rd    (mid_rd),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.up_wdata  (up_wdata),
		.mid_wdata (mid_wdata),
		.v_s2      (v_s2),
		.v_s3      (v_s3),
		.meta_s3   (meta_s3),
		.sqx_s3    (sqx_s3),
		.sqy_s3    (sqy_s3)
	);

	gsed_out #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.m_tready   (m_tready),
		.v_s3       (v_s3),
		.meta_s3    (meta_s3),
		.sqx_s3     (sqx_s3),
		.sqy_s3     (sqy_s3),
		.threshold  (cfg_thresh_q),
		.edge_value (cfg_edge_q),
		.adv_out    (adv_out),
		.m_tvalid   (m_tvalid),
		.cur_q      (res)
	);

	// Output packing.
	assign m_tdata = {{(gsed_pkg::M_TDATA_W - gsed_pkg::RES_BITS){1'b0}},
		res.col, res.row, res.value};
	assign m_tlast = res.last;

	// A buffer write and a read in the same cycle never meet at one column.
	a_lb_no_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("line buffer read and write at the same column");

	// The final result of a frame lies on the border and is zero.
	a_last_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (res.value == '0))
		else $error("frame end result is not zero");

endmodule

`default_nettype wire
